### hw/rtl/aeskx_pkg.sv
`default_nettype none

package aeskx_pkg;

  localparam int unsigned NumRounds = 11;
  localparam logic [3:0]  LastRound = 4'(NumRounds - 1);

  typedef enum logic {
    StIdle,
    StRun
  } aeskx_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;   // capture a new cipher key
    logic       step;   // advance to the next round key
    logic [3:0] rnd;    // index of the round key being produced by step
  } aeskx_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant for round keys 1..10
  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] val;
    val = 8'h00;
    unique case (rnd)
      4'd1:    val = 8'h01;
      4'd2:    val = 8'h02;
      4'd3:    val = 8'h04;
      4'd4:    val = 8'h08;
      4'd5:    val = 8'h10;
      4'd6:    val = 8'h20;
      4'd7:    val = 8'h40;
      4'd8:    val = 8'h80;
      4'd9:    val = 8'h1b;
      4'd10:   val = 8'h36;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/aes128_key_expansion_core.sv
`default_nettype none
// AES-128 key expansion.
// Input channel (in_valid_i/in_ready_o): one transaction carries a 128-bit cipher
// key as key_high_i (bytes 0..7) and key_low_i (bytes 8..15), byte 0 in bit 63.
// Output channel (out_valid_o/out_ready_i): each key yields 11 transactions,
// round keys 0..10 in order, with round_number_o and last_o set on round 10.
// Round key 0 appears the cycle after the key is taken; each following round key
// is computed by a single S-box/XOR round stage when the previous one is taken.
// The next key is taken in the same cycle as the last round key, so keys follow
// one another without an idle gap.
// A stalled receiver simply holds the current round key; the round stage waits.
// The block works on one key at a time; in_ready_o is low while round keys
// 0..9 are pending.
// Reset returns the controller to idle, ready for a key; any run in progress
// is dropped.
module aes128_key_expansion_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] key_high_i,
  input  wire logic [63:0] key_low_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       round_number_o,
  output logic [63:0]      round_key_high_o,
  output logic [63:0]      round_key_low_o,
  output logic             last_o
);
  import aeskx_pkg::*;

  aeskx_cmd_t cmd;

  aeskx_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .round_number_o,
    .last_o,
    .cmd_o (cmd)
  );

  aeskx_datapath u_datapath (
    .clk_i,
    .cmd_i (cmd),
    .key_high_i,
    .key_low_i,
    .round_key_high_o,
    .round_key_low_o
  );

endmodule

`default_nettype wire

### hw/rtl/aeskx_datapath.sv
`default_nettype none

module aeskx_datapath (
  input  wire logic                clk_i,
  input  wire aeskx_pkg::aeskx_cmd_t cmd_i,
  input  wire logic [63:0]         key_high_i,
  input  wire logic [63:0]         key_low_i,
  output logic [63:0]              round_key_high_o,
  output logic [63:0]              round_key_low_o
);
  import aeskx_pkg::*;

  logic [31:0] w0_q, w1_q, w2_q, w3_q;
  logic [31:0] w0_d, w1_d, w2_d, w3_d;
  logic [31:0] g;

  // RotWord then SubWord on the last word, rcon into the top byte
  always_comb begin
    g = {SBOX[w3_q[23:16]], SBOX[w3_q[15:8]], SBOX[w3_q[7:0]], SBOX[w3_q[31:24]]}
        ^ {rcon(cmd_i.rnd), 24'h000000};
    w0_d = w0_q ^ g;
    w1_d = w1_q ^ w0_d;
    w2_d = w2_q ^ w1_d;
    w3_d = w3_q ^ w2_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w0_q <= key_high_i[63:32];
      w1_q <= key_high_i[31:0];
      w2_q <= key_low_i[63:32];
      w3_q <= key_low_i[31:0];
    end else if (cmd_i.step) begin
      w0_q <= w0_d;
      w1_q <= w1_d;
      w2_q <= w2_d;
      w3_q <= w3_d;
    end
  end

  assign round_key_high_o = {w0_q, w1_q};
  assign round_key_low_o  = {w2_q, w3_q};

endmodule

`default_nettype wire

### hw/rtl/aeskx_ctrl.sv
`default_nettype none

module aeskx_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [3:0]          round_number_o,
  output logic                last_o,
  output aeskx_pkg::aeskx_cmd_t cmd_o
);
  import aeskx_pkg::*;

  aeskx_state_e state_q, state_d;
  logic [3:0]   round_q, round_d;
  logic         in_fire, out_fire, is_last;

  assign is_last  = (round_q == LastRound);
  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    round_d = round_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StRun;
          round_d = 4'd0;
        end
      end
      StRun: begin
        if (in_fire) begin
          round_d = 4'd0;
        end else if (out_fire) begin
          if (is_last) begin
            state_d = StIdle;
          end else begin
            round_d = round_q + 4'd1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs; a new key may be taken in the cycle the last round key leaves
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: in_ready_o = 1'b1;
      StRun: begin
        out_valid_o = 1'b1;
        in_ready_o  = is_last & out_ready_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_o.load = in_fire;
    cmd_o.step = out_fire & ~is_last;
    cmd_o.rnd  = round_q + 4'd1;
  end

  assign round_number_o = round_q;
  assign last_o         = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= 4'd0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] key_high_i;
  logic [63:0] key_low_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  round_number_o;
  logic [63:0] round_key_high_o;
  logic [63:0] round_key_low_o;
  logic        last_o;

  typedef struct packed {
    logic [3:0]  rnd;
    logic [63:0] rk_high;
    logic [63:0] rk_low;
    logic        last;
  } round_key_t;

  localparam logic [7:0] SBOX_TABLE [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  round_key_t  expected_round_keys[$];
  int unsigned error_count;
  int unsigned burst_left;
  bit          allow_gaps;
  bit          force_ready;
  logic [15:0] stall_pattern;

  aes128_key_expansion_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .key_high_i       (key_high_i),
    .key_low_i        (key_low_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .round_number_o   (round_number_o),
    .round_key_high_o (round_key_high_o),
    .round_key_low_o  (round_key_low_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Full AES-128 schedule for one key, all 11 round keys queued in order
  task automatic expand_key(input logic [63:0] k_high, input logic [63:0] k_low);
    logic [31:0] w [4];
    logic [31:0] g;
    logic [7:0]  rc;
    round_key_t  rk;
    w[0] = k_high[63:32];
    w[1] = k_high[31:0];
    w[2] = k_low[63:32];
    w[3] = k_low[31:0];
    rc = 8'h01;
    for (int r = 0; r < aeskx_pkg::NumRounds; r++) begin
      if (r > 0) begin
        g = {w[3][23:0], w[3][31:24]};
        g = {SBOX_TABLE[g[31:24]], SBOX_TABLE[g[23:16]],
             SBOX_TABLE[g[15:8]], SBOX_TABLE[g[7:0]]} ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
        w[0] = w[0] ^ g;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
      end
      rk.rnd     = 4'(r);
      rk.rk_high = {w[0], w[1]};
      rk.rk_low  = {w[2], w[3]};
      rk.last    = (4'(r) == aeskx_pkg::LastRound);
      expected_round_keys.push_back(rk);
    end
  endtask

  // Called right after a rising edge; returns at the edge that took the key, or later after a random idle gap
  task automatic send_key(input logic [63:0] k_high, input logic [63:0] k_low);
    int unsigned gap;
    in_valid_i <= 1'b1;
    key_high_i <= k_high;
    key_low_i  <= k_low;
    do @(posedge clk_i); while (!in_ready_o);
    expand_key(k_high, k_low);
    if (allow_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(0, 12);
        burst_left = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  task automatic test_directed_keys();
    allow_gaps = 1'b1;
    send_key(64'h0, 64'h0);
    send_key('1, '1);
    send_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);  // standard example key
    send_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_key('1, 64'h0);
    send_key(64'h0, '1);
    send_key(64'h0000000000000001, 64'h8000000000000000);
    send_key(64'h8000000000000000, 64'h0000000000000001);
    send_key(64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0);
    send_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    // last word drives RotWord/SubWord: push its bytes through the extremes
    send_key(64'h0, 64'h00000000ffffffff);
    send_key(64'h0, 64'h0000000080402010);
    send_key('1, 64'hffffffff00000000);
  endtask

  task automatic test_random_keys(input int unsigned count);
    logic [63:0] k_high;
    logic [63:0] k_low;
    allow_gaps = 1'b1;
    repeat (count) begin
      case ($urandom_range(0, 4))
        0: begin
          k_high = 64'h1 << $urandom_range(0, 63);
          k_low  = ~(64'h1 << $urandom_range(0, 63));
        end
        1: begin
          k_high = {$urandom, $urandom} & {$urandom, $urandom};
          k_low  = {$urandom, $urandom} | {$urandom, $urandom};
        end
        default: begin
          k_high = {$urandom, $urandom};
          k_low  = {$urandom, $urandom};
        end
      endcase
      send_key(k_high, k_low);
    end
  endtask

  // Back-to-back keys with the receiver always ready: next key overlaps round 10
  task automatic test_streaming_keys(input int unsigned count);
    allow_gaps  = 1'b0;
    force_ready = 1'b1;
    repeat (count) send_key({$urandom, $urandom}, {$urandom, $urandom});
    force_ready = 1'b0;
    allow_gaps  = 1'b1;
  endtask

  // Receiver stall pattern, reloaded every so often; sometimes never stalls
  initial begin
    int unsigned age;
    out_ready_i   = 1'b0;
    stall_pattern = 16'hffff;
    age = 0;
    forever begin
      @(posedge clk_i);
      age++;
      if (age >= 48) begin
        age = 0;
        stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
      end else begin
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
      out_ready_i <= force_ready | stall_pattern[0];
    end
  end

  always @(posedge clk_i) begin
    round_key_t exp_rk;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_round_keys.size() == 0) begin
        report_mismatch($sformatf("unexpected round key, round %0d", round_number_o));
      end else begin
        exp_rk = expected_round_keys.pop_front();
        if (round_number_o !== exp_rk.rnd)
          report_mismatch($sformatf("round_number %0d, expected %0d",
                                    round_number_o, exp_rk.rnd));
        if (round_key_high_o !== exp_rk.rk_high)
          report_mismatch($sformatf("round %0d high %h, expected %h",
                                    exp_rk.rnd, round_key_high_o, exp_rk.rk_high));
        if (round_key_low_o !== exp_rk.rk_low)
          report_mismatch($sformatf("round %0d low %h, expected %h",
                                    exp_rk.rnd, round_key_low_o, exp_rk.rk_low));
        if (last_o !== exp_rk.last)
          report_mismatch($sformatf("round %0d last %b, expected %b",
                                    exp_rk.rnd, last_o, exp_rk.last));
      end
    end
  end

  initial begin
    error_count = 0;
    burst_left  = 0;
    allow_gaps  = 1'b1;
    force_ready = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    key_high_i  = '0;
    key_low_i   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_keys();
    test_random_keys(120);
    test_streaming_keys(30);
    test_random_keys(50);

    in_valid_i <= 1'b0;
    while (expected_round_keys.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("aes128_key_expansion_core verification clean");
    end else begin
      $display("aes128_key_expansion_core verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("aes128_key_expansion_core verification failed");
    $finish;
  end

endmodule
